FILE: src/gdo_pkg.sv
package gdo_pkg;

  // field widths
  localparam int unsigned DayW    = 5;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned YearW   = 14;
  localparam int unsigned OffW    = 16;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned StatW   = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;

  // working widths: signed day count and signed year during the walk
  localparam int unsigned AccW  = 17;
  localparam int unsigned EyW   = 15;
  localparam int unsigned R400W = 9;
  localparam int unsigned PcW   = 4;

  localparam int unsigned YearMax = 9999;

  // year / 400 by reciprocal: q = (y * Recip400) >> Recip400Sh, exact below 43690
  localparam int unsigned Recip400   = 41944;
  localparam int unsigned Recip400Sh = 24;
  localparam int unsigned RecipW     = 16;
  localparam int unsigned ProdW      = YearW + RecipW;
  localparam int unsigned QuotW      = ProdW - Recip400Sh;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADDATE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL,
    OP_MOD,
    OP_INIT,
    OP_ADDOFF,
    OP_YFWD,
    OP_YBWD,
    OP_MINIT,
    OP_MSTEP,
    OP_FIN
  } op_e;

  // jump conditions
  typedef enum logic [1:0] {
    CND_ALWAYS,
    CND_YGT,
    CND_YLT,
    CND_MGT
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] tgt_t;
    logic [PcW-1:0] tgt_f;
    logic           last;
  } ctrl_t;

  // program steps
  localparam logic [PcW-1:0] PC_MUL   = 4'd0;
  localparam logic [PcW-1:0] PC_MOD   = 4'd1;
  localparam logic [PcW-1:0] PC_INIT  = 4'd2;
  localparam logic [PcW-1:0] PC_ADD   = 4'd3;
  localparam logic [PcW-1:0] PC_YFWD  = 4'd4;
  localparam logic [PcW-1:0] PC_YBWD  = 4'd5;
  localparam logic [PcW-1:0] PC_MINIT = 4'd6;
  localparam logic [PcW-1:0] PC_MSTEP = 4'd7;
  localparam logic [PcW-1:0] PC_FIN   = 4'd8;

  // control store
  function automatic ctrl_t ucode(input logic [PcW-1:0] pc);
    ctrl_t c;
    c = '{op: OP_FIN, cond: CND_ALWAYS, tgt_t: PC_FIN, tgt_f: PC_FIN, last: 1'b1};
    unique case (pc)
      PC_MUL:   c = '{OP_MUL,    CND_ALWAYS, PC_MOD,   PC_MOD,   1'b0};
      PC_MOD:   c = '{OP_MOD,    CND_ALWAYS, PC_INIT,  PC_INIT,  1'b0};
      PC_INIT:  c = '{OP_INIT,   CND_ALWAYS, PC_ADD,   PC_ADD,   1'b0};
      PC_ADD:   c = '{OP_ADDOFF, CND_ALWAYS, PC_YFWD,  PC_YFWD,  1'b0};
      PC_YFWD:  c = '{OP_YFWD,   CND_YGT,    PC_YFWD,  PC_YBWD,  1'b0};
      PC_YBWD:  c = '{OP_YBWD,   CND_YLT,    PC_YBWD,  PC_MINIT, 1'b0};
      PC_MINIT: c = '{OP_MINIT,  CND_ALWAYS, PC_MSTEP, PC_MSTEP, 1'b0};
      PC_MSTEP: c = '{OP_MSTEP,  CND_MGT,    PC_MSTEP, PC_FIN,   1'b0};
      PC_FIN:   c = '{OP_FIN,    CND_ALWAYS, PC_FIN,   PC_FIN,   1'b1};
      default:  c = '{OP_FIN,    CND_ALWAYS, PC_FIN,   PC_FIN,   1'b1};
    endcase
    return c;
  endfunction

  // leap year from low year bits and year mod 400
  function automatic logic is_leap(input logic [1:0] ylo, input logic [R400W-1:0] r400);
    return (ylo == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: src/gregorian_date_offset_top.sv
// Adds a signed day offset to a proleptic Gregorian date (years 0..9999) and returns the
// resulting day, month, year, ordinal day of year and a status (0 ok, 1 invalid input
// date, 2 result year out of range; on a nonzero status the input date is echoed and
// day_of_year is 0). One transaction is in flight at a time: a small microprogram walks
// whole years one per cycle, then months one per cycle. The next input is taken as soon
// as the result is loaded into the output register, while that result still waits.
module gregorian_date_offset_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // start_day[4:0], start_month[8:5], start_year[22:9], day_offset[38:23], zero[39]
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // end_day[4:0], end_month[8:5], end_year[22:9], day_of_year[31:23], status[33:32],
  // zero[39:34]
  output logic [39:0] m_axis_tdata_o
);

  // sequencer state
  logic                        busy_q, busy_d;
  logic [gdo_pkg::PcW-1:0]     pc_q, pc_d;
  logic                        mval_q, mval_d;

  // latched input
  logic [gdo_pkg::DayW-1:0]    d_q;
  logic [gdo_pkg::MonthW-1:0]  m_q;
  logic [gdo_pkg::YearW-1:0]   y_q;
  logic signed [gdo_pkg::OffW-1:0] off_q;

  // datapath registers
  logic [gdo_pkg::ProdW-1:0]       prod_q, prod_d;
  logic [gdo_pkg::R400W-1:0]       r400_q, r400_d;
  logic signed [gdo_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [gdo_pkg::EyW-1:0]  ey_q, ey_d;
  logic [gdo_pkg::MonthW-1:0]      em_q, em_d;
  logic [gdo_pkg::DoyW-1:0]        doy_q, doy_d;
  logic [gdo_pkg::StatW-1:0]       st_q, st_d;

  // output register
  logic [gdo_pkg::OutDataW-1:0]    out_q, out_d;

  gdo_pkg::ctrl_t ctrl;
  logic           accept;
  logic           stall;
  logic           cond_ok;
  logic           abort;

  // year walk helpers
  logic                          leap_cur, leap_prv, leap_in;
  logic [gdo_pkg::R400W-1:0]     r400_inc, r400_dec;
  logic [gdo_pkg::DoyW-1:0]      ylen_cur, ylen_prv;
  logic [gdo_pkg::DayW-1:0]      mlen_cur, mlen_in;
  logic [gdo_pkg::QuotW-1:0]     quot;
  logic [gdo_pkg::YearW-1:0]     qmul;
  logic                          bad_in;

  assign ctrl   = gdo_pkg::ucode(pc_q);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy_q;
  assign m_axis_tvalid_o = mval_q;
  assign m_axis_tdata_o  = out_q;

  // leap and length lookups
  assign r400_inc = (r400_q == 9'd399) ? 9'd0 : r400_q + 9'd1;
  assign r400_dec = (r400_q == 9'd0) ? 9'd399 : r400_q - 9'd1;
  assign leap_cur = gdo_pkg::is_leap(ey_q[1:0], r400_q);
  assign leap_prv = gdo_pkg::is_leap(ey_q[1:0] - 2'd1, r400_dec);
  assign leap_in  = gdo_pkg::is_leap(y_q[1:0], r400_q);
  assign ylen_cur = leap_cur ? 9'd366 : 9'd365;
  assign ylen_prv = leap_prv ? 9'd366 : 9'd365;
  assign mlen_cur = gdo_pkg::month_len(em_q, leap_cur);
  assign mlen_in  = gdo_pkg::month_len(m_q, leap_in);
  assign quot     = prod_q[gdo_pkg::ProdW-1:gdo_pkg::Recip400Sh];
  assign qmul     = gdo_pkg::YearW'({quot, 8'd0} + {quot, 7'd0} + {quot, 4'd0});
  assign bad_in   = (m_q == 4'd0) || (m_q > 4'd12) || (y_q > 14'(gdo_pkg::YearMax)) ||
                    (d_q == 5'd0) || (d_q > mlen_in);

  // branch condition
  always_comb begin
    unique case (ctrl.cond)
      gdo_pkg::CND_ALWAYS: cond_ok = 1'b1;
      gdo_pkg::CND_YGT:    cond_ok = acc_q > $signed({8'd0, ylen_cur});
      gdo_pkg::CND_YLT:    cond_ok = acc_q < 17'sd1;
      gdo_pkg::CND_MGT:    cond_ok = (em_q < 4'd12) && (acc_q > $signed({12'd0, mlen_cur}));
      default:             cond_ok = 1'b0;
    endcase
  end

  // datapath and sequencer
  always_comb begin
    prod_d = prod_q;
    r400_d = r400_q;
    acc_d  = acc_q;
    ey_d   = ey_q;
    em_d   = em_q;
    doy_d  = doy_q;
    st_d   = st_q;
    out_d  = out_q;
    busy_d = busy_q;
    pc_d   = pc_q;
    mval_d = mval_q && !m_axis_tready_i;
    abort  = 1'b0;
    stall  = ctrl.last && mval_q && !m_axis_tready_i;

    if (accept) begin
      busy_d = 1'b1;
      pc_d   = gdo_pkg::PC_MUL;
      st_d   = gdo_pkg::ST_OK;
    end else if (busy_q && !stall) begin
      if (cond_ok) begin
        unique case (ctrl.op)
          gdo_pkg::OP_MUL: begin
            prod_d = y_q * 16'(gdo_pkg::Recip400);
          end
          gdo_pkg::OP_MOD: begin
            r400_d = gdo_pkg::R400W'(y_q - qmul);
          end
          gdo_pkg::OP_INIT: begin
            if (bad_in) begin
              st_d  = gdo_pkg::ST_BADDATE;
              abort = 1'b1;
            end
            acc_d = $signed({8'd0, gdo_pkg::days_before(m_q)}) + $signed({12'd0, d_q}) +
                    $signed({16'd0, (leap_in && (m_q > 4'd2))});
            ey_d  = $signed({1'b0, y_q});
          end
          gdo_pkg::OP_ADDOFF: begin
            acc_d = acc_q + 17'(off_q);
          end
          gdo_pkg::OP_YFWD: begin
            acc_d  = acc_q - $signed({8'd0, ylen_cur});
            ey_d   = ey_q + 15'sd1;
            r400_d = r400_inc;
            if (ey_q >= 15'(gdo_pkg::YearMax)) begin
              st_d  = gdo_pkg::ST_RANGE;
              abort = 1'b1;
            end
          end
          gdo_pkg::OP_YBWD: begin
            ey_d   = ey_q - 15'sd1;
            r400_d = r400_dec;
            acc_d  = acc_q + $signed({8'd0, ylen_prv});
            if (ey_q == 15'sd0) begin
              st_d  = gdo_pkg::ST_RANGE;
              abort = 1'b1;
            end
          end
          gdo_pkg::OP_MINIT: begin
            em_d  = 4'd1;
            doy_d = acc_q[gdo_pkg::DoyW-1:0];
          end
          gdo_pkg::OP_MSTEP: begin
            acc_d = acc_q - $signed({12'd0, mlen_cur});
            em_d  = em_q + 4'd1;
          end
          gdo_pkg::OP_FIN: begin
            if (st_q == gdo_pkg::ST_OK) begin
              out_d = {6'd0, st_q, doy_q, ey_q[gdo_pkg::YearW-1:0], em_q,
                       acc_q[gdo_pkg::DayW-1:0]};
            end else begin
              out_d = {6'd0, st_q, 9'd0, y_q, m_q, d_q};
            end
          end
          default: begin
          end
        endcase
      end

      // next step
      if (ctrl.last) begin
        busy_d = 1'b0;
        mval_d = 1'b1;
      end else if (abort) begin
        pc_d = gdo_pkg::PC_FIN;
      end else begin
        pc_d = cond_ok ? ctrl.tgt_t : ctrl.tgt_f;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= gdo_pkg::PC_MUL;
      mval_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      mval_q <= mval_d;
    end
  end

  // input capture on an accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      d_q   <= s_axis_tdata_i[4:0];
      m_q   <= s_axis_tdata_i[8:5];
      y_q   <= s_axis_tdata_i[22:9];
      off_q <= $signed(s_axis_tdata_i[38:23]);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    r400_q <= r400_d;
    acc_q  <= acc_d;
    ey_q   <= ey_d;
    em_q   <= em_d;
    doy_q  <= doy_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;

  localparam int CycleLimit    = 1_000_000;
  localparam int NumDirected   = 25;
  localparam int NumPhases     = 5;
  localparam int ItemsPerPhase = 180;
  localparam int DrainCycles   = 200;
  localparam int LastYear      = gdo_pkg::YearMax;

  // one result transaction as it appears on m_axis_tdata_o, lowest field last
  typedef struct packed {
    gdo_pkg::status_e            status;
    logic [gdo_pkg::DoyW-1:0]    doy;
    logic [gdo_pkg::YearW-1:0]   year;
    logic [gdo_pkg::MonthW-1:0]  month;
    logic [gdo_pkg::DayW-1:0]    day;
  } date_result_t;

  typedef struct {
    int           day;
    int           month;
    int           year;
    int           offset;
    bit           typed;
    date_result_t res;
  } dir_row_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  // start_day[4:0], start_month[8:5], start_year[22:9], day_offset[38:23], zero[39]
  logic [gdo_pkg::InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  // end_day[4:0], end_month[8:5], end_year[22:9], day_of_year[31:23], status[33:32],
  // zero[39:34]
  logic [gdo_pkg::OutDataW-1:0] m_axis_tdata_o;

  date_result_t expected_dates[$];
  date_result_t want;
  int           errors      = 0;
  int           cycle_count = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct  = 0;
  int           send_idle[NumPhases]  = '{0, 79, 0, 29, 0};
  int           recv_stall[NumPhases] = '{0, 0, 79, 29, 0};

  // directed cases: typed result only where it is obvious
  dir_row_t directed_rows[NumDirected] = '{
    '{1,  1,  2000,  0,      1, '{gdo_pkg::ST_OK,      1,   2000,  1,  1}},
    '{31, 12, 9999,  1,      1, '{gdo_pkg::ST_RANGE,   0,   9999,  12, 31}},
    '{1,  1,  0,     -1,     1, '{gdo_pkg::ST_RANGE,   0,   0,     1,  1}},
    '{1,  1,  50,    -32768, 1, '{gdo_pkg::ST_RANGE,   0,   50,    1,  1}},
    '{0,  1,  2000,  5,      1, '{gdo_pkg::ST_BADDATE, 0,   2000,  1,  0}},
    '{1,  0,  2000,  5,      1, '{gdo_pkg::ST_BADDATE, 0,   2000,  0,  1}},
    '{1,  13, 2000,  5,      1, '{gdo_pkg::ST_BADDATE, 0,   2000,  13, 1}},
    '{31, 15, 16383, -32768, 1, '{gdo_pkg::ST_BADDATE, 0,   16383, 15, 31}},
    '{1,  6,  10000, 0,      1, '{gdo_pkg::ST_BADDATE, 0,   10000, 6,  1}},
    '{29, 2,  1900,  0,      1, '{gdo_pkg::ST_BADDATE, 0,   1900,  2,  29}},
    '{31, 4,  2021,  0,      1, '{gdo_pkg::ST_BADDATE, 0,   2021,  4,  31}},
    '{31, 11, 2021,  0,      1, '{gdo_pkg::ST_BADDATE, 0,   2021,  11, 31}},
    '{29, 2,  2000,  0,      1, '{gdo_pkg::ST_OK,      60,  2000,  2,  29}},
    '{1,  3,  2000,  -1,     1, '{gdo_pkg::ST_OK,      60,  2000,  2,  29}},
    '{28, 2,  2100,  1,      1, '{gdo_pkg::ST_OK,      60,  2100,  3,  1}},
    '{1,  1,  2001,  -1,     1, '{gdo_pkg::ST_OK,      366, 2000,  12, 31}},
    '{31, 12, 9999,  0,      1, '{gdo_pkg::ST_OK,      365, 9999,  12, 31}},
    '{1,  1,  0,     0,      1, '{gdo_pkg::ST_OK,      1,   0,     1,  1}},
    '{1,  1,  0,     32767,  0, '0},
    '{31, 12, 9999,  -32768, 0, '0},
    '{29, 2,  2400,  366,    0, '0},
    '{30, 4,  2021,  -400,   0, '0},
    '{31, 7,  1600,  1,      0, '0},
    '{29, 2,  2096,  -1461,  0, '0},
    '{15, 8,  1999,  12345,  0, '0}
  };

  gregorian_date_offset_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // calendar rules
  function automatic bit leap_year(input int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int days_in_month(input int m, input int y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic int days_in_year(input int y);
    return leap_year(y) ? 366 : 365;
  endfunction

  // date plus offset, walking years then months
  function automatic date_result_t add_days(input int d, input int m, input int y,
                                            input int off);
    date_result_t     r;
    int               doy;
    int               ey;
    int               em;
    int               i;
    gdo_pkg::status_e st;
    r.day    = gdo_pkg::DayW'(d);
    r.month  = gdo_pkg::MonthW'(m);
    r.year   = gdo_pkg::YearW'(y);
    r.doy    = '0;
    r.status = gdo_pkg::ST_OK;
    if (m < 1 || m > 12 || y > LastYear || d < 1 || d > days_in_month(m, y)) begin
      r.status = gdo_pkg::ST_BADDATE;
      return r;
    end
    doy = d;
    for (i = 1; i < m; i++) doy += days_in_month(i, y);
    doy += off;
    ey = y;
    st = gdo_pkg::ST_OK;
    while (st == gdo_pkg::ST_OK && doy > days_in_year(ey)) begin
      doy -= days_in_year(ey);
      ey++;
      if (ey > LastYear) st = gdo_pkg::ST_RANGE;
    end
    while (st == gdo_pkg::ST_OK && doy < 1) begin
      ey--;
      if (ey < 0) st = gdo_pkg::ST_RANGE;
      else doy += days_in_year(ey);
    end
    if (st != gdo_pkg::ST_OK) begin
      r.status = st;
      return r;
    end
    r.doy = gdo_pkg::DoyW'(doy);
    em = 1;
    while (em < 12 && doy > days_in_month(em, ey)) begin
      doy -= days_in_month(em, ey);
      em++;
    end
    r.day   = gdo_pkg::DayW'(doy);
    r.month = gdo_pkg::MonthW'(em);
    r.year  = gdo_pkg::YearW'(ey);
    return r;
  endfunction

  function automatic logic [gdo_pkg::InDataW-1:0] pack_request(input int d, input int m,
                                                               input int y, input int off);
    return {1'b0, off[15:0], y[13:0], m[3:0], d[4:0]};
  endfunction

  // mostly valid dates near the interesting years, some raw noise
  function automatic logic [gdo_pkg::InDataW-1:0] random_request();
    int d;
    int m;
    int y;
    int off;
    if ($urandom_range(99) < 10) begin
      d = $urandom_range(31);
      m = $urandom_range(15);
      y = $urandom_range(16383);
    end else begin
      m = $urandom_range(1, 12);
      case ($urandom_range(3))
        0:       y = $urandom_range(9999);
        1:       y = $urandom_range(120);
        2:       y = $urandom_range(9999, 9880);
        default: y = $urandom_range(99) * 100 + $urandom_range(1);
      endcase
      if ($urandom_range(7) == 0) d = days_in_month(m, y);
      else d = $urandom_range(1, days_in_month(m, y));
    end
    case ($urandom_range(2))
      0:       off = $urandom_range(65535) - 32768;
      1:       off = $urandom_range(800) - 400;
      default: off = $urandom_range(40) - 20;
    endcase
    return pack_request(d, m, y, off);
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_request(input logic [gdo_pkg::InDataW-1:0] word, input bit use_typed,
                              input date_result_t typed_res);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (use_typed) expected_dates.push_back(typed_res);
    else expected_dates.push_back(add_days(word[4:0], word[8:5], word[22:9],
                                           $signed(word[38:23])));
  endtask

  // hold the input side until all pending results are out
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // output backpressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_dates.size() == 0) begin
        $error("result transaction with nothing pending: %h", m_axis_tdata_o);
        errors++;
      end else begin
        want = expected_dates.pop_front();
        check_field("end_day", want.day, m_axis_tdata_o[4:0]);
        check_field("end_month", want.month, m_axis_tdata_o[8:5]);
        check_field("end_year", want.year, m_axis_tdata_o[22:9]);
        check_field("day_of_year", want.doy, m_axis_tdata_o[31:23]);
        check_field("status", want.status, m_axis_tdata_o[33:32]);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cases, no idling
    for (int r = 0; r < NumDirected; r++) begin
      send_request(pack_request(directed_rows[r].day, directed_rows[r].month,
                                directed_rows[r].year, directed_rows[r].offset),
                   directed_rows[r].typed, directed_rows[r].res);
    end

    // random phases with different idle patterns
    for (int p = 0; p < NumPhases; p++) begin
      sender_idle_pct = send_idle[p];
      recv_stall_pct  = recv_stall[p];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
      if (p == 1) drain_results();
    end

    // wait for the tail, then a little longer for stray results
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
